@@ design/tef_pkg.sv @@
// Shared constants, types and the power-curve table of the envelope follower.
`timescale 1ns / 1ps
`default_nettype none
package tef_pkg;

  // Q0.24 levels and the fixed constants of the transfer curve
  localparam logic [24:0] ONE_Q24   = 25'd16777216;
  localparam logic [23:0] MAX_Q24   = 24'd16777215;
  localparam logic [25:0] THREE_Q24 = 26'd50331648;
  localparam logic [24:0] THR_BASE  = 25'd167772;    // 0.010
  localparam logic [19:0] THR_SPAN  = 20'd570425;    // 0.034
  localparam logic [29:0] GAIN_BASE = 30'd125829120; // 7.5
  localparam logic [24:0] SAT_LIMIT = 25'd28521267;  // 1.7

  // Register resets, coefficients given at 24 bits
  localparam logic [15:0] SENS_RST = 16'd32768;
  localparam logic [23:0] ATK_Q24  = 24'd167772;
  localparam logic [23:0] REL_Q24  = 24'd8389;
  localparam logic [23:0] SMO_Q24  = 24'd87161;

  // Divider: 24 quotient bits, two per step
  localparam int DIV_STEPS = 12;
  localparam int DIV_CNT_W = $clog2(DIV_STEPS);

  typedef enum logic [1:0] {
    REG_SENS    = 2'd0,
    REG_ATTACK  = 2'd1,
    REG_RELEASE = 2'd2,
    REG_SMOOTH  = 2'd3
  } cfg_reg_t;

  typedef struct packed {
    logic        start;
    logic [24:0] scaled;
  } div_req_t;

  typedef struct packed {
    logic        done;
    logic [23:0] quot;
  } div_rsp_t;

  // x^0.62 at 33 points over [0, 1], Q0.24
  function automatic logic [24:0] pow_tab(input logic [5:0] idx);
    logic [24:0] v;
    unique case (idx)
      6'd0:  v = 25'd0;
      6'd1:  v = 25'd1956712;
      6'd2:  v = 25'd3007224;
      6'd3:  v = 25'd3866714;
      6'd4:  v = 25'd4621727;
      6'd5:  v = 25'd5307479;
      6'd6:  v = 25'd5942659;
      6'd7:  v = 25'd6538643;
      6'd8:  v = 25'd7103016;
      6'd9:  v = 25'd7641124;
      6'd10: v = 25'd8156932;
      6'd11: v = 25'd8653472;
      6'd12: v = 25'd9133124;
      6'd13: v = 25'd9597801;
      6'd14: v = 25'd10049080;
      6'd15: v = 25'd10488262;
      6'd16: v = 25'd10916448;
      6'd17: v = 25'd11334575;
      6'd18: v = 25'd11743455;
      6'd19: v = 25'd12143787;
      6'd20: v = 25'd12536187;
      6'd21: v = 25'd12921201;
      6'd22: v = 25'd13299307;
      6'd23: v = 25'd13670935;
      6'd24: v = 25'd14036473;
      6'd25: v = 25'd14396261;
      6'd26: v = 25'd14750622;
      6'd27: v = 25'd15099843;
      6'd28: v = 25'd15444181;
      6'd29: v = 25'd15783876;
      6'd30: v = 25'd16119149;
      6'd31: v = 25'd16450200;
      6'd32: v = 25'd16777216;
      default: v = 25'd0;
    endcase
    return v;
  endfunction

endpackage
`default_nettype wire

@@ design/tef_mul.sv @@
// Shared registered multiplier: operand registers, then product register.
`timescale 1ns / 1ps
`default_nettype none
module tef_mul #(
  parameter int A_W = 25,
  parameter int B_W = 30
) (
  input  wire logic               clk,
  input  wire logic               ld,
  input  wire logic [A_W-1:0]     a,
  input  wire logic [B_W-1:0]     b,
  output logic      [A_W+B_W-1:0] p
);

  logic [A_W-1:0]     a_r;
  logic [B_W-1:0]     b_r;
  logic [A_W+B_W-1:0] p_r;

  always_ff @(posedge clk) begin
    if (ld) begin
      a_r <= a;
      b_r <= b;
    end
    p_r <= a_r * b_r;
  end

  assign p = p_r;

endmodule
`default_nettype wire

@@ design/tef_div.sv @@
// Radix-4 restoring divider for the s/(1+s) compression, rounded quotient.
`timescale 1ns / 1ps
`default_nettype none
module tef_div (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire tef_pkg::div_req_t req,
  output tef_pkg::div_rsp_t      rsp
);

  logic [25:0] den;
  logic [49:0] num;
  logic [25:0] d_r;
  logic [25:0] rem_r;
  logic [23:0] low_r;
  logic [23:0] q_r;
  logic [tef_pkg::DIV_CNT_W-1:0] cnt_r;
  logic        busy_r;
  logic        done_r;
  logic [26:0] t1;
  logic [26:0] r1;
  logic [26:0] t2;
  logic [26:0] r2;
  logic        ge1;
  logic        ge2;

  // numerator is s * 2^24 plus half the divisor, for round to nearest
  assign den = 26'(tef_pkg::ONE_Q24) + 26'(req.scaled);
  assign num = {1'b0, req.scaled, 24'd0} + 50'(den >> 1);

  always_comb begin
    t1  = {rem_r, low_r[23]};
    ge1 = (t1 >= {1'b0, d_r});
    r1  = ge1 ? (t1 - {1'b0, d_r}) : t1;
    t2  = {r1[25:0], low_r[22]};
    ge2 = (t2 >= {1'b0, d_r});
    r2  = ge2 ? (t2 - {1'b0, d_r}) : t2;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == tef_pkg::DIV_CNT_W'(tef_pkg::DIV_STEPS - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // quotient fits 24 bits, so the top of the numerator is already below the divisor
  always_ff @(posedge clk) begin
    if (req.start) begin
      d_r   <= den;
      rem_r <= num[49:24];
      low_r <= num[23:0];
    end else if (busy_r) begin
      rem_r <= r2[25:0];
      low_r <= {low_r[21:0], 2'b00};
      q_r   <= {q_r[21:0], ge1, ge2};
    end
  end

  assign rsp.done = done_r;
  assign rsp.quot = q_r;

endmodule
`default_nettype wire

@@ design/threshold_envelope_follower.sv @@
// Top level of the threshold envelope follower: sequencer, state and ports.
//
// One signed sample in, one smoothed control value out. The input stream
// (in_tvalid/in_tready/in_tdata) carries one sample per transfer; the output
// stream (out_tvalid/out_tready/out_tdata) carries one Q0.24 control value per
// sample. The write port (cfg_we/cfg_addr/cfg_wdata) sets sensitivity and the
// attack, release and smoothing coefficients; write it only while idle.
// A small sequencer walks every sample through one shared registered
// multiplier (nine products) and a radix-4 divider (twelve steps) for the
// s/(1+s) compression. out_tvalid rises when the sequencer finishes a
// sample, and in_tready returns in that same cycle, so a new sample is
// taken only once the previous one is through. The multiplier chain and the
// divider set how long a sample takes.
// in_tready is high only while the sequencer is idle. The result sits in an
// output register, so a new sample is taken while it waits; if the receiver
// still stalls when the next result is done, the sequencer holds it until
// the output register frees up.
// Reset (rst_n low, synchronous) clears envelope and control levels to zero,
// loads the register defaults and drops out_tvalid.
`timescale 1ns / 1ps
`default_nettype none
module threshold_envelope_follower #(
  parameter int SAMPLE_BITS = 24,
  parameter int COEF_BITS   = 24
) (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  // input stream
  input  wire logic                             in_tvalid,
  output logic                                  in_tready,
  input  wire logic [((SAMPLE_BITS+7)/8)*8-1:0] in_tdata,  // [SAMPLE_BITS-1:0] sample_in
  // result stream
  output logic                                  out_tvalid,
  input  wire logic                             out_tready,
  output logic [23:0]                           out_tdata, // [23:0] control_out
  // register writes
  input  wire logic                             cfg_we,
  input  wire logic [1:0]                       cfg_addr,
  input  wire logic [COEF_BITS-1:0]             cfg_wdata
);

  localparam int MUL_AW = (COEF_BITS > 25) ? COEF_BITS : 25;
  localparam int MUL_BW = 30;
  localparam int MUL_PW = MUL_AW + MUL_BW;
  localparam int SH_UP  = (COEF_BITS >= 24) ? COEF_BITS - 24 : 0;
  localparam int SH_DN  = (COEF_BITS < 24) ? 24 - COEF_BITS : 0;
  localparam logic [COEF_BITS-1:0] ATK_RST =
    COEF_BITS'((64'(tef_pkg::ATK_Q24) << SH_UP) >> SH_DN);
  localparam logic [COEF_BITS-1:0] REL_RST =
    COEF_BITS'((64'(tef_pkg::REL_Q24) << SH_UP) >> SH_DN);
  localparam logic [COEF_BITS-1:0] SMO_RST =
    COEF_BITS'((64'(tef_pkg::SMO_Q24) << SH_UP) >> SH_DN);

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_M_SQ,  ST_C_SQ,
    ST_M_SS,  ST_C_SS,
    ST_M_THR, ST_C_THR,
    ST_RECT,
    ST_M_SCL, ST_C_SCL,
    ST_DIV_GO, ST_DIV_WAIT,
    ST_ENV_D, ST_M_ENV, ST_C_ENV,
    ST_POW_D, ST_M_POW, ST_C_POW,
    ST_M_SH1, ST_C_SH1,
    ST_M_SH2, ST_C_SH2,
    ST_CTL_D, ST_M_CTL, ST_C_CTL,
    ST_OUT
  } state_t;

  state_t state_r;

  // configuration
  logic [15:0]          sens_r;
  logic [COEF_BITS-1:0] atk_r;
  logic [COEF_BITS-1:0] rel_r;
  logic [COEF_BITS-1:0] smo_r;

  // levels kept from sample to sample
  logic [23:0] env_r;
  logic [23:0] control_r;

  // per-sample working registers
  logic [24:0] mag_r;
  logic [24:0] ss_r;
  logic [24:0] thr_r;
  logic [29:0] gain_r;
  logic [24:0] scaled_r;
  logic [23:0] target_r;
  logic        dn_r;
  logic [24:0] lo_r;
  logic [24:0] xs_r;
  logic [23:0] shaped_r;

  logic        out_tvalid_r;
  logic [23:0] out_tdata_r;

  logic in_xfer;
  assign in_tready = (state_r == ST_IDLE);
  assign in_xfer   = in_tvalid && in_tready;

  // rectify and bring the sample to Q0.24 (full-scale negative gives 1.0)
  logic [SAMPLE_BITS-1:0] raw;
  logic [SAMPLE_BITS-1:0] absval;
  logic [24:0]            mag;

  assign raw    = in_tdata[SAMPLE_BITS-1:0];
  assign absval = raw[SAMPLE_BITS-1] ? (~raw + 1'b1) : raw;

  if (SAMPLE_BITS >= 25) begin : g_mag_down
    assign mag = 25'(absval >> (SAMPLE_BITS - 25));
  end else begin : g_mag_up
    assign mag = 25'(absval) << (25 - SAMPLE_BITS);
  end

  // shared multiplier
  logic              mul_ld;
  logic [MUL_AW-1:0] mul_a;
  logic [MUL_BW-1:0] mul_b;
  logic [MUL_PW-1:0] mul_p;

  tef_mul #(
    .A_W (MUL_AW),
    .B_W (MUL_BW)
  ) u_mul (
    .clk (clk),
    .ld  (mul_ld),
    .a   (mul_a),
    .b   (mul_b),
    .p   (mul_p)
  );

  // divider
  tef_pkg::div_req_t div_req;
  tef_pkg::div_rsp_t div_rsp;

  assign div_req.start  = (state_r == ST_DIV_GO);
  assign div_req.scaled = scaled_r;

  tef_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  // round the product: one adder, the half picked by the step in progress
  logic [MUL_PW-1:0] half;
  logic [MUL_PW-1:0] rnd_sum;
  logic [24:0]       rnd24;
  logic [30:0]       rnd24w;
  logic [24:0]       rnd19;
  logic [24:0]       rndc;

  always_comb begin
    case (state_r) inside
      ST_C_POW:           half = MUL_PW'(1) << 18;
      ST_C_ENV, ST_C_CTL: half = MUL_PW'(1) << (COEF_BITS - 1);
      default:            half = MUL_PW'(1) << 23;
    endcase
  end

  assign rnd_sum = mul_p + half;
  assign rnd24   = rnd_sum[24 +: 25];
  assign rnd24w  = rnd_sum[24 +: 31];
  assign rnd19   = rnd_sum[19 +: 25];
  assign rndc    = rnd_sum[COEF_BITS +: 25];

  // smoothstep operands: x = sens as Q0.24 for the threshold, x = x^0.62 later
  logic [23:0] ssx;
  logic [25:0] ss_t;
  logic [25:0] sh_t;
  assign ssx  = {sens_r, 8'h00};
  assign ss_t = tef_pkg::THREE_Q24 - {1'b0, ssx, 1'b0};
  assign sh_t = tef_pkg::THREE_Q24 - {xs_r, 1'b0};

  logic [24:0] rect;
  assign rect = (mag_r > thr_r) ? (mag_r - thr_r) : 25'd0;

  // one-pole follow: shared difference for envelope and control smoothing
  logic                 fol_ctl;
  logic [23:0]          fol_x;
  logic [23:0]          fol_y;
  logic [24:0]          fol_diff;
  logic                 fol_dn;
  logic [23:0]          fol_d;
  logic [COEF_BITS-1:0] fol_coef;
  logic [23:0]          fol_res;

  assign fol_ctl  = (state_r == ST_CTL_D) || (state_r == ST_C_CTL);
  assign fol_x    = fol_ctl ? shaped_r : target_r;
  assign fol_y    = fol_ctl ? control_r : env_r;
  assign fol_diff = {1'b0, fol_x} - {1'b0, fol_y};
  assign fol_dn   = fol_diff[24];
  assign fol_d    = fol_dn ? 24'(~fol_diff + 1'b1) : fol_diff[23:0];
  // equal levels take the release coefficient (step is zero either way)
  assign fol_coef = fol_ctl ? smo_r :
                    ((!fol_dn && (fol_diff != 25'd0)) ? atk_r : rel_r);
  assign fol_res  = dn_r ? (fol_y - rndc[23:0]) : (fol_y + rndc[23:0]);

  // power curve: table segment plus rounded interpolation
  logic [4:0]  pidx;
  logic [24:0] p_lo;
  logic [24:0] p_hi;
  logic [20:0] span;
  logic [24:0] pw;
  logic [24:0] pw_clamp;

  assign pidx     = env_r[23:19];
  assign p_lo     = tef_pkg::pow_tab({1'b0, pidx});
  assign p_hi     = tef_pkg::pow_tab({1'b0, pidx} + 6'd1);
  assign span     = 21'(p_hi - p_lo);
  assign pw       = lo_r + rnd19;
  assign pw_clamp = (pw > tef_pkg::ONE_Q24) ? tef_pkg::ONE_Q24 : pw;

  // multiplier operand selection: load in the step before each product
  always_comb begin
    mul_ld = 1'b0;
    mul_a  = '0;
    mul_b  = '0;
    unique case (state_r)
      ST_IDLE: begin
        mul_ld = in_xfer;
        mul_a  = MUL_AW'(ssx);
        mul_b  = MUL_BW'(ssx);
      end
      ST_C_SQ: begin
        mul_ld = 1'b1;
        mul_a  = MUL_AW'(rnd24);
        mul_b  = MUL_BW'(ss_t);
      end
      ST_C_SS: begin
        mul_ld = 1'b1;
        mul_a  = MUL_AW'(tef_pkg::ONE_Q24 - rnd24);
        mul_b  = MUL_BW'(tef_pkg::THR_SPAN);
      end
      ST_RECT: begin
        mul_ld = 1'b1;
        mul_a  = MUL_AW'(rect);
        mul_b  = gain_r;
      end
      ST_ENV_D, ST_CTL_D: begin
        mul_ld = 1'b1;
        mul_a  = MUL_AW'(fol_coef);
        mul_b  = MUL_BW'(fol_d);
      end
      ST_POW_D: begin
        mul_ld = 1'b1;
        mul_a  = MUL_AW'(span);
        mul_b  = MUL_BW'(env_r[18:0]);
      end
      ST_C_POW: begin
        mul_ld = 1'b1;
        mul_a  = MUL_AW'(pw_clamp);
        mul_b  = MUL_BW'(pw_clamp);
      end
      ST_C_SH1: begin
        mul_ld = 1'b1;
        mul_a  = MUL_AW'(rnd24);
        mul_b  = MUL_BW'(sh_t);
      end
      default: begin
        mul_ld = 1'b0;
      end
    endcase
  end

  // register writes; control state, levels and the result valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sens_r       <= tef_pkg::SENS_RST;
      atk_r        <= ATK_RST;
      rel_r        <= REL_RST;
      smo_r        <= SMO_RST;
      env_r        <= '0;
      control_r    <= '0;
      state_r      <= ST_IDLE;
      out_tvalid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (tef_pkg::cfg_reg_t'(cfg_addr))
          tef_pkg::REG_SENS:    sens_r <= cfg_wdata[15:0];
          tef_pkg::REG_ATTACK:  atk_r  <= cfg_wdata;
          tef_pkg::REG_RELEASE: rel_r  <= cfg_wdata;
          tef_pkg::REG_SMOOTH:  smo_r  <= cfg_wdata;
        endcase
      end

      // drop the result once it is taken; in ST_OUT the result step decides
      if (out_tvalid_r && out_tready && (state_r != ST_OUT)) begin
        out_tvalid_r <= 1'b0;
      end

      unique case (state_r)
        ST_IDLE:     if (in_xfer) state_r <= ST_M_SQ;
        ST_M_SQ:     state_r <= ST_C_SQ;
        ST_C_SQ:     state_r <= ST_M_SS;
        ST_M_SS:     state_r <= ST_C_SS;
        ST_C_SS:     state_r <= ST_M_THR;
        ST_M_THR:    state_r <= ST_C_THR;
        ST_C_THR:    state_r <= ST_RECT;
        ST_RECT:     state_r <= ST_M_SCL;
        ST_M_SCL:    state_r <= ST_C_SCL;
        ST_C_SCL:    state_r <= ST_DIV_GO;
        ST_DIV_GO:   state_r <= ST_DIV_WAIT;
        ST_DIV_WAIT: if (div_rsp.done) state_r <= ST_ENV_D;
        ST_ENV_D:    state_r <= ST_M_ENV;
        ST_M_ENV:    state_r <= ST_C_ENV;
        ST_C_ENV: begin
          env_r   <= fol_res;
          state_r <= ST_POW_D;
        end
        ST_POW_D:    state_r <= ST_M_POW;
        ST_M_POW:    state_r <= ST_C_POW;
        ST_C_POW:    state_r <= ST_M_SH1;
        ST_M_SH1:    state_r <= ST_C_SH1;
        ST_C_SH1:    state_r <= ST_M_SH2;
        ST_M_SH2:    state_r <= ST_C_SH2;
        ST_C_SH2:    state_r <= ST_CTL_D;
        ST_CTL_D:    state_r <= ST_M_CTL;
        ST_M_CTL:    state_r <= ST_C_CTL;
        ST_C_CTL: begin
          control_r <= fol_res;
          state_r   <= ST_OUT;
        end
        ST_OUT: begin
          // hold until the output register is free
          if (!out_tvalid_r || out_tready) begin
            out_tvalid_r <= 1'b1;
            state_r      <= ST_IDLE;
          end
        end
        default:     state_r <= ST_IDLE;
      endcase
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    unique case (state_r)
      ST_IDLE: if (in_xfer) mag_r <= mag;
      ST_C_SS: ss_r <= rnd24;
      ST_C_THR: begin
        thr_r  <= tef_pkg::THR_BASE + rnd24;
        // gain = 7.5 + 28 * ss
        gain_r <= tef_pkg::GAIN_BASE + {ss_r, 5'd0} - 30'({ss_r, 2'd0});
      end
      ST_C_SCL: begin
        scaled_r <= (rnd24w > 31'(tef_pkg::SAT_LIMIT)) ? tef_pkg::SAT_LIMIT
                                                      : rnd24w[24:0];
      end
      ST_DIV_WAIT: if (div_rsp.done) target_r <= div_rsp.quot;
      ST_ENV_D, ST_CTL_D: dn_r <= fol_dn;
      ST_POW_D: lo_r <= p_lo;
      ST_C_POW: xs_r <= pw_clamp;
      ST_C_SH2: begin
        // a shaped value of exactly 1.0 saturates to full scale
        shaped_r <= (rnd24 > 25'(tef_pkg::MAX_Q24)) ? tef_pkg::MAX_Q24 : rnd24[23:0];
      end
      ST_OUT: if (!out_tvalid_r || out_tready) out_tdata_r <= control_r;
      default: begin
      end
    endcase
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;

endmodule
`default_nettype wire
